// File: hdl/page_lock_manager_with_wait_queue_macros.svh
// Assertion macros used by the page lock manager datapath.
`ifndef PAGE_LOCK_MANAGER_WITH_WAIT_QUEUE_MACROS_SVH
`define PAGE_LOCK_MANAGER_WITH_WAIT_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/plm_pkg.sv
// Shared widths, status codes and control types of the page lock manager.
package plm_pkg;

    localparam int PAGE_W = 12;
    localparam int REQ_W  = 8;
    localparam int STAT_W = 3;

    localparam logic [STAT_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_QUEUED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_HANDOFF  = 3'd2;
    localparam logic [STAT_W-1:0] ST_RELEASED = 3'd3;
    localparam logic [STAT_W-1:0] ST_ERROR    = 3'd4;

    typedef struct packed {
        logic clear;
        logic accept;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
    } t_dp_stat;

endpackage

// File: hdl/plm_ctrl.sv
// Controller state machine: clearing pass, idle and request execution.
module plm_ctrl
    import plm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_cmd.clear  = (r_state == S_CLEAR);
    assign o_cmd.accept = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec   = (r_state == S_EXEC);

endmodule

// File: hdl/plm_datapath.sv
// Datapath: held-page bitmap memory, waiter queue and result registers.
`include "page_lock_manager_with_wait_queue_macros.svh"
module plm_datapath
    import plm_pkg::*;
#(
    parameter int PAGES   = 4096,
    parameter int WAITERS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic              i_req_type,
    input  logic [PAGE_W-1:0] i_page_index,
    input  logic [REQ_W-1:0]  i_requester_id,
    output logic              o_strobe,
    output logic [STAT_W-1:0] o_status,
    output logic [REQ_W-1:0]  o_grant_requester,
    output logic [PAGE_W-1:0] o_grant_page
);

    localparam int AW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW = $clog2(WAITERS + 1);
    localparam int IW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(PAGES - 1);

    logic r_held_mem [PAGES];
    logic r_held;

    logic              r_req_type;
    logic [PAGE_W-1:0] r_page;
    logic [REQ_W-1:0]  r_who;

    logic [PAGE_W-1:0] r_wpage [WAITERS];
    logic [REQ_W-1:0]  r_wreq  [WAITERS];
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    logic [AW-1:0] r_clr_addr;

    logic              r_strobe;
    logic [STAT_W-1:0] r_status;
    logic [REQ_W-1:0]  r_grant_req;
    logic [PAGE_W-1:0] r_grant_page;

    logic [STAT_W-1:0] n_status;
    logic [REQ_W-1:0]  n_grant_req;
    logic [PAGE_W-1:0] n_grant_page;

    logic [WAITERS-1:0] hit;
    logic               any_hit;
    logic [IW-1:0]      hit_idx;
    logic               in_range;
    logic               do_append;
    logic               do_remove;
    logic               mem_wr;
    logic               mem_wdata;
    logic [AW-1:0]      mem_waddr;

    always_comb begin
        for (int i = 0; i < WAITERS; i++) begin
            hit[i] = (CW'(i) < r_count) && (r_wpage[i] == r_page);
        end
        hit_idx = '0;
        for (int i = WAITERS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                hit_idx = IW'(i);
            end
        end
    end

    assign any_hit  = |hit;
    assign in_range = (32'(r_page) < 32'(PAGES));

    always_comb begin
        n_status     = ST_ERROR;
        n_grant_req  = '0;
        n_grant_page = '0;
        n_count      = r_count;
        do_append    = 1'b0;
        do_remove    = 1'b0;
        mem_wr       = 1'b0;
        mem_wdata    = 1'b0;
        mem_waddr    = AW'(r_page);
        if (i_cmd.clear) begin
            mem_wr    = 1'b1;
            mem_waddr = r_clr_addr;
        end else if (i_cmd.exec && in_range) begin
            if (!r_req_type) begin
                if (!r_held) begin
                    n_status     = ST_GRANTED;
                    n_grant_req  = r_who;
                    n_grant_page = r_page;
                    mem_wr       = 1'b1;
                    mem_wdata    = 1'b1;
                end else if (r_count != CW'(WAITERS)) begin
                    n_status     = ST_QUEUED;
                    n_grant_page = r_page;
                    do_append    = 1'b1;
                    n_count      = r_count + CW'(1);
                end
            end else if (r_held) begin
                if (any_hit) begin
                    n_status     = ST_HANDOFF;
                    n_grant_req  = r_wreq[hit_idx];
                    n_grant_page = r_page;
                    do_remove    = 1'b1;
                    n_count      = r_count - CW'(1);
                end else begin
                    n_status     = ST_RELEASED;
                    n_grant_page = r_page;
                    mem_wr       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_held_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.accept) begin
            r_held <= r_held_mem[AW'(i_page_index)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type <= i_req_type;
            r_page     <= i_page_index;
            r_who      <= i_requester_id;
        end
        for (int k = 0; k < WAITERS - 1; k++) begin
            if (do_remove && (IW'(k) >= hit_idx)) begin
                r_wpage[k] <= r_wpage[k + 1];
                r_wreq[k]  <= r_wreq[k + 1];
            end
        end
        if (do_append) begin
            r_wpage[r_count[IW-1:0]] <= r_page;
            r_wreq[r_count[IW-1:0]]  <= r_who;
        end
        if (i_cmd.exec) begin
            r_status     <= n_status;
            r_grant_req  <= n_grant_req;
            r_grant_page <= n_grant_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_clr_addr <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= i_cmd.exec;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    assign o_stat.clear_done = i_cmd.clear && (r_clr_addr == CLR_LAST);

    assign o_strobe          = r_strobe;
    assign o_status          = r_status;
    assign o_grant_requester = r_grant_req;
    assign o_grant_page      = r_grant_page;

    `PLM_ASSERT_NEXT(a_queue_grows, i_cmd.exec && (n_status == ST_QUEUED),
        r_count == $past(r_count) + CW'(1), "Queued request did not add a waiter.")
    `PLM_ASSERT_NEXT(a_queue_shrinks, i_cmd.exec && (n_status == ST_HANDOFF),
        r_count == $past(r_count) - CW'(1), "Handoff did not remove a waiter.")
    `PLM_ASSERT_SAME(a_handoff_held, i_cmd.exec && (n_status == ST_HANDOFF),
        r_held && r_req_type, "Handoff on a page that is not held.")

endmodule

// File: hdl/page_lock_manager_with_wait_queue.sv
// Top level of the page lock manager with its queue of waiting requesters.
//
// A request is taken when start is high and busy is low. It carries the
// request type (lock or unlock), a page number and the requester's identity.
// Exactly one result follows for every request: o_strobe is high for one
// cycle with the status, the page (zero on an error) and, on a grant or
// handoff, the requester that now owns it. The request is registered,
// evaluated while busy is high and the result is registered, so a new
// request is not taken before the last one has been evaluated. This wait
// is set by the single-port bitmap memory of held pages: the page's bit is
// read first, then evaluated against the waiter queue and written back.
// After reset the block clears the bitmap one page per cycle; busy stays
// high throughout and no request is taken.
// The waiter queue is empty after reset.
// The receiver cannot stall: each result is valid for its strobe cycle only.
module page_lock_manager_with_wait_queue
    import plm_pkg::*;
#(
    parameter int PAGES   = 4096,
    parameter int WAITERS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [PAGE_W-1:0] i_page_index,
    input  logic [REQ_W-1:0]  i_requester_id,
    output logic              o_strobe,
    output logic [STAT_W-1:0] o_status,
    output logic [REQ_W-1:0]  o_grant_requester,
    output logic [PAGE_W-1:0] o_grant_page
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    plm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    plm_datapath #(
        .PAGES   (PAGES),
        .WAITERS (WAITERS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_req_type        (i_req_type),
        .i_page_index      (i_page_index),
        .i_requester_id    (i_requester_id),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_grant_requester (o_grant_requester),
        .o_grant_page      (o_grant_page)
    );

endmodule
